>>> hw/rtl/frustum_cull_tester_top_defines.svh
// ----------------------------------------------------------------------------
// frustum cull tester assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TESTER_TOP_DEFINES_SVH
`define FRUSTUM_CULL_TESTER_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define FCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum cull tester check failed");

// consequent checked in the next cycle
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum cull tester check failed");

`endif

>>> hw/rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// types and constants of the frustum cull tester
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PLANE_W    = 3;
  localparam int COEF_W     = 32;
  localparam int HALF_W     = 31;
  localparam int PROD_W     = 64;
  localparam int ACC_W      = 68;
  localparam int FRAC_W     = 16;
  localparam int NUM_COEFS  = 4;

  localparam logic [PLANE_W-1:0] FIRST_SIDE_PLANE = 3'd2;
  localparam logic [PLANE_W-1:0] LAST_PLANE       = PLANE_W'(NUM_PLANES - 1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SPHERE = 2'd1,
    OP_SIDES  = 2'd2,
    OP_BOX    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MAG,
    ST_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         plane_sel;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic was_test;
  } out_item_t;

  typedef struct packed {
    logic take_item;
    logic mul_centre;
    logic mul_mag;
    logic acc_add;
    logic check;
    logic next_plane;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic new_load;
    logic box;
    logic last_plane;
  } status_t;

endpackage

>>> hw/rtl/fct_ctrl.sv
// ----------------------------------------------------------------------------
// fct_ctrl
// sequencer: steps the datapath through the planes of one transaction
// ----------------------------------------------------------------------------
module fct_ctrl
  import fct_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.new_load ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: state_d = status_i.box ? ST_MAG : ST_ADD;
      ST_MAG: state_d = ST_ADD;
      ST_ADD: state_d = status_i.last_plane ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.take_item = in_valid_i;
      ST_MUL:  cmd_o.mul_centre = 1'b1;
      ST_MAG: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.mul_mag = 1'b1;
      end
      ST_ADD: begin
        cmd_o.acc_add    = 1'b1;
        cmd_o.check      = 1'b1;
        cmd_o.next_plane = 1'b1;
      end
      ST_DONE: cmd_o.push = out_free;
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_d = cmd_o.push || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/fct_datapath.sv
// ----------------------------------------------------------------------------
// fct_datapath
// plane store, three multipliers, wide accumulator and result register
// ----------------------------------------------------------------------------
module fct_datapath
  import fct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [HALF_W-1:0] cfg_wdata_i,
  input  in_item_t          in_data_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output out_item_t         out_data_o
);

  logic signed [COEF_W-1:0] plane_q [NUM_PLANES][NUM_COEFS];
  logic [HALF_W-1:0]        eps_q;

  logic [1:0]               op_q;
  logic signed [COEF_W-1:0] cx_q, cy_q, cz_q;
  logic [HALF_W-1:0]        hx_q, hy_q, hz_q;
  logic [COEF_W-1:0]        margin_q, margin_d;
  logic [PLANE_W-1:0]       plane_q_idx, plane_d_idx;
  logic signed [PROD_W-1:0] prod_q [3];
  logic signed [PROD_W-1:0] prod_d [3];
  logic signed [ACC_W-1:0]  acc_q, acc_d, acc_sum, base;
  logic                     cull_q;
  out_item_t                out_q;

  logic signed [COEF_W-1:0] ra, rb, rc, rd;
  logic signed [COEF_W-1:0] ma, mb, mc;
  logic                     is_box;

  assign ra = plane_q[plane_q_idx][0];
  assign rb = plane_q[plane_q_idx][1];
  assign rc = plane_q[plane_q_idx][2];
  assign rd = plane_q[plane_q_idx][3];

  // minus magnitude of each normal component, always fits 32 bits
  assign ma = ra[COEF_W-1] ? ra : -ra;
  assign mb = rb[COEF_W-1] ? rb : -rb;
  assign mc = rc[COEF_W-1] ? rc : -rc;

  assign is_box = (op_q == OP_BOX);

  always_comb begin
    if (cmd_i.mul_mag) begin
      prod_d[0] = ma * $signed({1'b0, hx_q});
      prod_d[1] = mb * $signed({1'b0, hy_q});
      prod_d[2] = mc * $signed({1'b0, hz_q});
    end else begin
      prod_d[0] = ra * cx_q;
      prod_d[1] = rb * cy_q;
      prod_d[2] = rc * cz_q;
    end
  end

  assign base = (ACC_W'(rd) - $signed(ACC_W'(margin_q))) <<< FRAC_W;

  assign acc_sum = acc_q + ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2]);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_centre) begin
      acc_d = base;
    end else if (cmd_i.acc_add) begin
      acc_d = acc_sum;
    end
  end

  assign margin_d = (in_data_i.op == OP_BOX) ? {1'b0, eps_q}
                                             : {1'b0, in_data_i.half_x} + {1'b0, eps_q};

  assign plane_d_idx = (in_data_i.op == OP_SIDES) ? FIRST_SIDE_PLANE : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < NUM_COEFS; k++) begin
          plane_q[p][k] <= '0;
        end
      end
      eps_q       <= '0;
      op_q        <= OP_LOAD;
      plane_q_idx <= '0;
      cull_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
      if (cmd_i.take_item) begin
        op_q        <= in_data_i.op;
        plane_q_idx <= plane_d_idx;
        cull_q      <= 1'b0;
        if (in_data_i.op == OP_LOAD && in_data_i.plane_sel < PLANE_W'(NUM_PLANES)) begin
          plane_q[in_data_i.plane_sel][0] <= in_data_i.coef_a;
          plane_q[in_data_i.plane_sel][1] <= in_data_i.coef_b;
          plane_q[in_data_i.plane_sel][2] <= in_data_i.coef_c;
          plane_q[in_data_i.plane_sel][3] <= in_data_i.coef_d;
        end
      end
      if (cmd_i.check && !acc_d[ACC_W-1] && (acc_d != '0)) begin
        cull_q <= 1'b1;
      end
      if (cmd_i.next_plane && plane_q_idx != LAST_PLANE) begin
        plane_q_idx <= plane_q_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      cx_q     <= in_data_i.center_x;
      cy_q     <= in_data_i.center_y;
      cz_q     <= in_data_i.center_z;
      hx_q     <= in_data_i.half_x;
      hy_q     <= in_data_i.half_y;
      hz_q     <= in_data_i.half_z;
      margin_q <= margin_d;
    end
    if (cmd_i.mul_centre || cmd_i.mul_mag) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
    if (cmd_i.push) begin
      out_q.was_test   <= (op_q != OP_LOAD);
      out_q.inside_res <= (op_q != OP_LOAD) && !cull_q;
    end
  end

  assign status_o.new_load   = (in_data_i.op == OP_LOAD);
  assign status_o.box        = is_box;
  assign status_o.last_plane = (plane_q_idx == LAST_PLANE);
  assign out_data_o          = out_q;

endmodule

>>> hw/rtl/frustum_cull_tester_top.sv
// ----------------------------------------------------------------------------
// frustum_cull_tester_top
// six-plane view-frustum culling of spheres, points and boxes in Q16.16
// ----------------------------------------------------------------------------
// One transaction at a time. Sphere, point, sides-only and box tests run a
// per-plane schedule through one bank of three 32x32 multipliers: a step
// for the centre products and one for their sum on each plane, one more per
// plane for the box half-extent products, plus a step to take the transaction
// and one to hand the result to the output register; a plane load has only
// these two. The result register lets a new transaction be taken while the
// last result is stalled. The user writes epsilon through cfg_we_i and
// cfg_wdata_i while the block is idle, which the block does not enforce.
module frustum_cull_tester_top
  import fct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [HALF_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  cmd_t    cmd;
  status_t status;

  fct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fct_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/fct_checker.sv
// ----------------------------------------------------------------------------
// fct_checker
// port-level checks of the frustum cull tester, bound to the top level
// ----------------------------------------------------------------------------
`include "frustum_cull_tester_top_defines.svh"

module fct_checker
  import fct_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // a stalled result stays put
  `FCT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  // one transaction in flight: stalled right after taking one
  `FCT_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // a plane load never reports inside
  `FCT_ASSERT_SAME(a_load_result, clk_i, rst_ni, out_valid_o && !out_data_o.was_test, !out_data_o.inside_res)

endmodule

bind frustum_cull_tester_top fct_checker u_fct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
